### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the descriptor builder modules. Defining
// NO_ASSERTIONS leaves every use empty.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define UTDB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define UTDB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define UTDB_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define UTDB_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### src/utdb_pkg.sv
// ----------------------------------------------------------------------------
// utdb_pkg
// Types, codes and field helpers of the USB1 transfer descriptor builder.
// ----------------------------------------------------------------------------
package utdb_pkg;

  localparam int MAX_PACKET_W = 10;
  localparam int PIPE_IDX_N   = 32;

  // Request command codes.
  localparam logic [1:0] CMD_CONTROL = 2'd0;
  localparam logic [1:0] CMD_BULK    = 2'd1;
  localparam logic [1:0] CMD_OPEN    = 2'd2;

  // Token PIDs.
  localparam logic [7:0] PID_OUT   = 8'hE1;
  localparam logic [7:0] PID_IN    = 8'h69;
  localparam logic [7:0] PID_SETUP = 8'h2D;

  // Status word bits.
  localparam logic [31:0] ST_SPD    = 32'h1 << 29;
  localparam logic [31:0] ST_CERR3  = 32'h3 << 27;
  localparam logic [31:0] ST_LS     = 32'h1 << 26;
  localparam logic [31:0] ST_IOC    = 32'h1 << 24;
  localparam logic [31:0] ST_ACTIVE = 32'h1 << 23;

  // Length field for a zero-byte packet, and for the 8-byte setup packet.
  localparam logic [10:0] LEN_NONE  = 11'h7FF;
  localparam logic [10:0] LEN_SETUP = 11'd7;

  localparam logic [15:0] CTRL_MAX_LEN = 16'd1023;

  typedef struct packed {
    logic [1:0]              command;
    logic [4:0]              pipe_index;
    logic                    dir_in;
    logic [6:0]              dev_addr;
    logic [3:0]              endpoint;
    logic                    low_speed;
    logic [MAX_PACKET_W-1:0] max_packet;
    logic [15:0]             length;
    logic [31:0]             setup_addr;
    logic [31:0]             data_addr;
  } req_t;

  typedef struct packed {
    logic [31:0] td_status;
    logic [31:0] td_token;
    logic [31:0] td_buffer;
    logic        last;
    logic        error;
  } td_t;

  typedef enum logic [2:0] {
    K_ERR,
    K_SETUP,
    K_DATA,
    K_STATUS,
    K_BULK
  } td_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ERR,
    ST_SETUP,
    ST_DATA,
    ST_STATUS,
    ST_BULK
  } ctrl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic     init_seq;
    logic     load_out;
    td_kind_t kind;
    logic     step;
    logic     wb_toggle;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_ctrl;
    logic req_err;
    logic has_data;
    logic bulk_fin;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [31:0] make_token(input logic [6:0] dev, input logic [3:0] ep,
                                             input logic tog, input logic [7:0] pid,
                                             input logic [10:0] len_field);
    make_token = {len_field, 1'b0, tog, ep, dev, pid};
  endfunction

endpackage

### src/utdb_if.sv
// ----------------------------------------------------------------------------
// utdb_if
// Valid/ready channels of the descriptor builder: request in, descriptor out.
// ----------------------------------------------------------------------------
interface utdb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [4:0]  pipe_index;
  logic        dir_in;
  logic [6:0]  dev_addr;
  logic [3:0]  endpoint;
  logic        low_speed;
  logic [9:0]  max_packet;
  logic [15:0] length;
  logic [31:0] setup_addr;
  logic [31:0] data_addr;

  modport source (output valid, command, pipe_index, dir_in, dev_addr, endpoint,
                  low_speed, max_packet, length, setup_addr, data_addr,
                  input ready);
  modport sink (input valid, command, pipe_index, dir_in, dev_addr, endpoint,
                low_speed, max_packet, length, setup_addr, data_addr,
                output ready);
endinterface

interface utdb_td_if;
  logic        valid;
  logic        ready;
  logic [31:0] td_status;
  logic [31:0] td_token;
  logic [31:0] td_buffer;
  logic        last;
  logic        error;

  modport source (output valid, td_status, td_token, td_buffer, last, error,
                  input ready);
  modport sink (input valid, td_status, td_token, td_buffer, last, error,
                output ready);
endinterface

### src/utdb_ctrl.sv
// ----------------------------------------------------------------------------
// utdb_ctrl
// Sequencer: takes a request, passes through the check stage for the checks
// and the toggle read, then steps the datapath through the descriptors of the chain.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utdb_ctrl
  import utdb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_ready,
  output dp_cmd_t    cmd,
  input  dp_stat_t   stat
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.kind   = K_ERR;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        // Pipe open and the unused code finish in the accept cycle.
        if (in_valid && (in_command == CMD_CONTROL || in_command == CMD_BULK)) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.init_seq = 1'b1;
        if (stat.req_err) begin
          state_next = ST_ERR;
        end else if (stat.is_ctrl) begin
          state_next = ST_SETUP;
        end else begin
          state_next = ST_BULK;
        end
      end
      ST_ERR: begin
        cmd.kind = K_ERR;
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_SETUP: begin
        cmd.kind = K_SETUP;
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = stat.has_data ? ST_DATA : ST_STATUS;
        end
      end
      ST_DATA: begin
        cmd.kind = K_DATA;
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_STATUS;
        end
      end
      ST_STATUS: begin
        cmd.kind = K_STATUS;
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_BULK: begin
        cmd.kind = K_BULK;
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          cmd.step     = 1'b1;
          if (stat.bulk_fin) begin
            cmd.wb_toggle = 1'b1;
            state_next    = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `UTDB_ASSERT_IMP(a_load_when_free, clk, rst, cmd.load_out, !stat.out_busy, "descriptor loaded over a held word")
  `UTDB_ASSERT_IMP(a_wb_on_final, clk, rst, cmd.wb_toggle, state == ST_BULK && stat.bulk_fin && cmd.load_out, "toggle written back before the final chunk")
  `UTDB_ASSERT_NXT(a_status_ends, clk, rst, state == ST_STATUS && cmd.load_out, state == ST_IDLE, "control chain did not end after the status stage")
  `UTDB_ASSERT_NXT(a_check_one_cycle, clk, rst, state == ST_CHECK, state != ST_CHECK && state != ST_IDLE, "check stage did not select a chain")

endmodule

### src/utdb_dp.sv
// ----------------------------------------------------------------------------
// utdb_dp
// Datapath: request registers, per-pipe toggle store, chunk walker and the
// output word register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utdb_dp
  import utdb_pkg::*;
#(
  parameter int PIPE_COUNT      = 32,
  parameter int MAX_DESCRIPTORS = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  req_t     req,
  input  logic     req_accept,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output td_t      td_word,
  output logic     td_valid,
  input  logic     td_ready
);

  localparam int PW = (PIPE_COUNT > 1) ? $clog2(PIPE_COUNT) : 1;
  localparam int MW = $clog2(MAX_DESCRIPTORS + 1);
  localparam int LW = MAX_PACKET_W + MW;
  localparam int CW = (LW > 16) ? LW : 16;

  // Pipe index reduced modulo the table size, one entry per index value.
  logic [PW-1:0] pipe_wrap [PIPE_IDX_N];

  genvar gi;
  generate
    for (gi = 0; gi < PIPE_IDX_N; gi++) begin : g_wrap
      assign pipe_wrap[gi] = PW'(gi % PIPE_COUNT);
    end
  endgenerate

  req_t            req_q;
  logic [PW-1:0]   pipe_q;
  logic [PW-1:0]   pipe_in;
  logic [LW-1:0]   lim;
  logic            tog_mem [PIPE_COUNT];
  logic [PIPE_COUNT-1:0] tog_vld;
  logic            mem_q;
  logic            vld_q;
  logic            tog;
  logic [15:0]     offset;

  assign pipe_in = pipe_wrap[req.pipe_index];

  always_ff @(posedge clk) begin
    if (req_accept) begin
      req_q  <= req;
      pipe_q <= pipe_in;
      // Largest length that still fits in the descriptor limit.
      lim    <= LW'(req.max_packet) * LW'(MAX_DESCRIPTORS);
      mem_q  <= tog_mem[pipe_in];
      vld_q  <= tog_vld[pipe_in];
    end
  end

  // Toggle store: an entry without its valid bit reads as zero.
  always_ff @(posedge clk) begin
    if (cmd.wb_toggle) begin
      tog_mem[pipe_q] <= ~tog;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tog_vld <= '0;
    end else if (req_accept && req.command == CMD_OPEN) begin
      tog_vld[pipe_in] <= 1'b0;
    end else if (cmd.wb_toggle) begin
      tog_vld[pipe_q] <= 1'b1;
    end
  end

  // Chunk walker.
  logic [15:0] rem;
  logic [15:0] mp16;
  logic [15:0] chunk;
  logic        fin;

  assign rem   = req_q.length - offset;
  assign mp16  = 16'(req_q.max_packet);
  assign fin   = rem <= mp16;
  assign chunk = fin ? rem : mp16;

  always_ff @(posedge clk) begin
    if (cmd.init_seq) begin
      tog    <= mem_q & vld_q;
      offset <= '0;
    end else if (cmd.step) begin
      tog    <= ~tog;
      offset <= offset + chunk;
    end
  end

  logic ctrl_err;
  logic bulk_err;

  assign ctrl_err = req_q.length > CTRL_MAX_LEN;
  assign bulk_err = (req_q.length == '0) || (req_q.max_packet == '0) ||
                    (CW'(req_q.length) > CW'(lim));

  assign stat.is_ctrl  = req_q.command == CMD_CONTROL;
  assign stat.req_err  = stat.is_ctrl ? ctrl_err : bulk_err;
  assign stat.has_data = req_q.length != '0;
  assign stat.bulk_fin = fin;
  assign stat.out_busy = td_valid && !td_ready;

  // Descriptor words.
  logic [31:0] st_base;
  logic [7:0]  pid_data;
  logic [7:0]  pid_status;
  td_t         td_next;

  assign st_base    = ST_ACTIVE | ST_CERR3 | (req_q.low_speed ? ST_LS : '0);
  assign pid_data   = req_q.dir_in ? PID_IN : PID_OUT;
  assign pid_status = req_q.dir_in ? PID_OUT : PID_IN;

  always_comb begin
    td_next = '0;
    unique case (cmd.kind)
      K_SETUP: begin
        td_next.td_status = st_base;
        td_next.td_token  = make_token(req_q.dev_addr, 4'd0, 1'b0, PID_SETUP, LEN_SETUP);
        td_next.td_buffer = req_q.setup_addr;
      end
      K_DATA: begin
        td_next.td_status = st_base | ST_SPD;
        td_next.td_token  = make_token(req_q.dev_addr, 4'd0, 1'b1, pid_data,
                                       11'(req_q.length - 16'd1));
        td_next.td_buffer = req_q.data_addr;
      end
      K_STATUS: begin
        td_next.td_status = st_base | ST_IOC;
        td_next.td_token  = make_token(req_q.dev_addr, 4'd0, 1'b1, pid_status, LEN_NONE);
        td_next.last      = 1'b1;
      end
      K_BULK: begin
        td_next.td_status = st_base | ST_SPD;
        td_next.td_token  = make_token(req_q.dev_addr, req_q.endpoint, tog, pid_data,
                                       11'(chunk - 16'd1));
        td_next.td_buffer = req_q.data_addr + 32'(offset);
        td_next.last      = fin;
      end
      default: begin
        // Rejected request: zero words, marked last.
        td_next.last  = 1'b1;
        td_next.error = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      td_word <= td_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      td_valid <= 1'b0;
    end else if (cmd.load_out) begin
      td_valid <= 1'b1;
    end else if (td_ready) begin
      td_valid <= 1'b0;
    end
  end

  `UTDB_ASSERT_IMP(a_err_is_last, clk, rst, td_valid && td_word.error, td_word.last && td_word.td_status == '0, "error word not marked last or not zero")
  `UTDB_ASSERT_IMP(a_step_in_range, clk, rst, cmd.step, offset < req_q.length, "chunk walker ran past the request length")

endmodule

### src/usb1_transfer_descriptor_builder.sv
// ----------------------------------------------------------------------------
// usb1_transfer_descriptor_builder
// Turns one transfer request into a chain of USB1 host transfer descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request word: control transfer, bulk transfer or pipe
//   open. td carries one descriptor word (status, token, buffer) per beat,
//   with last on the final descriptor of a chain and error on a rejection.
//   A pipe open, and the unused command code, finish in the accept cycle and
//   give no word. A control or bulk request passes through the check stage
//   (length limits, toggle read), then loads one descriptor per cycle into
//   the output register while the receiver keeps up: the first word is
//   loaded from the first descriptor state after the check stage, and the
//   block takes the next request once the last word of a chain is loaded.
//   So a control request gives 2 to 3 words, a rejected request 1 word, a
//   bulk request of n chunks n words, set by the single descriptor sequencer.
//   When the receiver stalls, the held word stays and the sequencer waits.
//   Reset clears the sequencer, the output valid and every stored toggle.
// ----------------------------------------------------------------------------
module usb1_transfer_descriptor_builder
  import utdb_pkg::*;
#(
  parameter int PIPE_COUNT      = 32,
  parameter int MAX_DESCRIPTORS = 64
) (
  input logic          clk,
  input logic          rst,
  utdb_req_if.sink     req,
  utdb_td_if.source    td
);

  req_t     req_word;
  logic     req_accept;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  td_t      td_word;

  assign req_word.command    = req.command;
  assign req_word.pipe_index = req.pipe_index;
  assign req_word.dir_in     = req.dir_in;
  assign req_word.dev_addr   = req.dev_addr;
  assign req_word.endpoint   = req.endpoint;
  assign req_word.low_speed  = req.low_speed;
  assign req_word.max_packet = req.max_packet;
  assign req_word.length     = req.length;
  assign req_word.setup_addr = req.setup_addr;
  assign req_word.data_addr  = req.data_addr;

  assign req_accept = req.valid && req.ready;

  utdb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.command),
    .in_ready   (req.ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  utdb_dp #(
    .PIPE_COUNT      (PIPE_COUNT),
    .MAX_DESCRIPTORS (MAX_DESCRIPTORS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .req        (req_word),
    .req_accept (req_accept),
    .cmd        (cmd),
    .stat       (stat),
    .td_word    (td_word),
    .td_valid   (td.valid),
    .td_ready   (td.ready)
  );

  assign td.td_status = td_word.td_status;
  assign td.td_token  = td_word.td_token;
  assign td.td_buffer = td_word.td_buffer;
  assign td.last      = td_word.last;
  assign td.error     = td_word.error;

endmodule

### dv/utdb_chain_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utdb_chain_checker
// Watches the request and descriptor channels of the descriptor builder.
// Every accepted request is expanded into the descriptor words it should
// produce, and every accepted descriptor word is compared in order against
// them, field by field.
// ----------------------------------------------------------------------------
module utdb_chain_checker
  import utdb_pkg::*;
#(
  parameter int PIPE_COUNT      = 32,
  parameter int MAX_DESCRIPTORS = 64
) (
  input  logic clk,
  input  logic rst,
  utdb_req_if  req,
  utdb_td_if   td,
  output int   fail_count,
  output int   pending,
  output int   req_count,
  output int   td_count,
  output int   reject_count
);

  localparam int REPORT_LIMIT = 10;

  logic pipe_toggles [PIPE_COUNT];
  td_t  expected_tds [$];
  int   mismatches;

  initial begin
    foreach (pipe_toggles[i]) pipe_toggles[i] = 1'b0;
    mismatches   = 0;
    fail_count   = 0;
    pending      = 0;
    req_count    = 0;
    td_count     = 0;
    reject_count = 0;
  end

  function automatic logic [31:0] token_word(input logic [6:0] dev, input logic [3:0] ep,
                                             input logic tog, input logic [7:0] pid,
                                             input int bytes);
    logic [10:0] len_field;
    len_field = (bytes == 0) ? LEN_NONE : 11'(bytes - 1);
    token_word = {len_field, 1'b0, tog, ep, dev, pid};
  endfunction

  task automatic push_td(input logic [31:0] status, input logic [31:0] token,
                         input logic [31:0] buffer, input logic last, input logic error);
    td_t d;
    d.td_status = status;
    d.td_token  = token;
    d.td_buffer = buffer;
    d.last      = last;
    d.error     = error;
    expected_tds.push_back(d);
  endtask

  // Expands one request into its descriptor chain and updates the toggles.
  task automatic predict_chain(input req_t r);
    logic [31:0] base;
    logic [7:0]  data_pid;
    logic        tog;
    int          pipe;
    int          len;
    int          mp;
    int          chunks;
    int          offset;
    int          chunk;
    pipe     = int'(r.pipe_index) % PIPE_COUNT;
    len      = int'(r.length);
    mp       = int'(r.max_packet);
    base     = ST_ACTIVE | ST_CERR3 | (r.low_speed ? ST_LS : 32'h0);
    data_pid = r.dir_in ? PID_IN : PID_OUT;
    case (r.command)
      CMD_OPEN: begin
        pipe_toggles[pipe] = 1'b0;
      end
      CMD_CONTROL: begin
        req_count++;
        if (r.length > CTRL_MAX_LEN) begin
          reject_count++;
          push_td(32'h0, 32'h0, 32'h0, 1'b1, 1'b1);
        end else begin
          push_td(base, token_word(r.dev_addr, 4'd0, 1'b0, PID_SETUP, 8), r.setup_addr,
                  1'b0, 1'b0);
          if (len > 0) begin
            push_td(base | ST_SPD, token_word(r.dev_addr, 4'd0, 1'b1, data_pid, len),
                    r.data_addr, 1'b0, 1'b0);
          end
          // The status stage always runs opposite to the data direction.
          push_td(base | ST_IOC,
                  token_word(r.dev_addr, 4'd0, 1'b1, r.dir_in ? PID_OUT : PID_IN, 0),
                  32'h0, 1'b1, 1'b0);
        end
      end
      CMD_BULK: begin
        req_count++;
        chunks = (mp == 0) ? 0 : (len + mp - 1) / mp;
        if (len == 0 || mp == 0 || chunks > MAX_DESCRIPTORS) begin
          reject_count++;
          push_td(32'h0, 32'h0, 32'h0, 1'b1, 1'b1);
        end else begin
          tog    = pipe_toggles[pipe];
          offset = 0;
          while (offset < len) begin
            chunk = (len - offset > mp) ? mp : len - offset;
            push_td(base | ST_SPD, token_word(r.dev_addr, r.endpoint, tog, data_pid, chunk),
                    r.data_addr + 32'(offset), (offset + chunk >= len), 1'b0);
            offset += chunk;
            tog = ~tog;
          end
          pipe_toggles[pipe] = tog;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_td(input td_t got);
    td_t want;
    if (expected_tds.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("MISMATCH: descriptor word with none expected: status %h token %h buffer %h",
                 got.td_status, got.td_token, got.td_buffer);
      end
    end else begin
      want = expected_tds.pop_front();
      if (got.td_status !== want.td_status || got.td_token !== want.td_token ||
          got.td_buffer !== want.td_buffer || got.last !== want.last ||
          got.error !== want.error) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("MISMATCH at word %0d: status %h/%h token %h/%h buffer %h/%h last %b/%b error %b/%b (expected/actual)",
                   td_count, want.td_status, got.td_status, want.td_token, got.td_token,
                   want.td_buffer, got.td_buffer, want.last, got.last, want.error, got.error);
        end
      end
    end
    td_count++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (td.valid && td.ready) begin
        check_td({td.td_status, td.td_token, td.td_buffer, td.last, td.error});
      end
      if (req.valid && req.ready) begin
        predict_chain({req.command, req.pipe_index, req.dir_in, req.dev_addr, req.endpoint,
                       req.low_speed, req.max_packet, req.length, req.setup_addr,
                       req.data_addr});
      end
    end
    fail_count <= mismatches;
    pending    <= expected_tds.size();
  end

endmodule

### dv/tb_usb1_transfer_descriptor_builder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_usb1_transfer_descriptor_builder
// Drives directed and random transfer requests into the descriptor builder
// with bursty input and a stalling receiver, and reports the verdict of the
// chain checker.
// ----------------------------------------------------------------------------
module tb_usb1_transfer_descriptor_builder
  import utdb_pkg::*;
();

  localparam logic [1:0] CMD_UNUSED         = 2'd3;
  localparam int         RANDOM_ITEMS       = 160;
  localparam int         LONG_HOLD          = 300;
  localparam int         TAIL_CYCLES        = 16;
  localparam int         MAX_DESCRIPTORS_TB = 64;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  int   req_count;
  int   td_count;
  int   reject_count;
  int   hold_go = 0;
  int   burst_left;

  utdb_req_if req_ch ();
  utdb_td_if  td_ch ();

  usb1_transfer_descriptor_builder u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .td  (td_ch)
  );

  utdb_chain_checker u_chain_chk (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .td           (td_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .req_count    (req_count),
    .td_count     (td_count),
    .reject_count (reject_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic req_t make_req(input logic [1:0] cmd, input logic [4:0] pipe,
                                    input logic dir, input logic [6:0] dev,
                                    input logic [3:0] ep, input logic ls,
                                    input logic [9:0] mp, input logic [15:0] len,
                                    input logic [31:0] saddr, input logic [31:0] daddr);
    make_req = {cmd, pipe, dir, dev, ep, ls, mp, len, saddr, daddr};
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    int   chunks;
    int   mp;
    r = make_req(CMD_BULK, 5'($urandom), 1'($urandom), 7'($urandom), 4'($urandom),
                 1'($urandom), 10'($urandom_range(1, 1023)), 16'h0, $urandom, $urandom);
    // A few pipes get most of the traffic so stored toggles carry over.
    if ($urandom_range(0, 1) == 0) r.pipe_index = 5'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      chunks = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
      mp = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 1023);
      r.max_packet = 10'(mp);
      r.length = 16'((chunks - 1) * mp + $urandom_range(1, mp));
    end else if (pick < 70) begin
      r.command = CMD_CONTROL;
      r.length = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 64))
                                             : 16'($urandom_range(0, 1023));
    end else if (pick < 78) begin
      r.command = CMD_CONTROL;
      r.length = 16'($urandom_range(1024, 65535));
    end else if (pick < 86) begin
      r.command = CMD_OPEN;
    end else if (pick < 90) begin
      r.command = CMD_UNUSED;
      r.length = 16'($urandom);
    end else begin
      case ($urandom_range(0, 2))
        0: r.length = 16'h0;
        1: begin
          r.max_packet = 10'h0;
          r.length = 16'($urandom);
        end
        default: begin
          mp = $urandom_range(1, 1022);
          r.max_packet = 10'(mp);
          r.length = 16'($urandom_range(MAX_DESCRIPTORS_TB * mp + 1, 65535));
        end
      endcase
    end
    random_request = r;
  endfunction

  // Offers one request word and returns at the edge where it is taken.
  task automatic offer(input req_t r);
    req_ch.valid <= 1'b1;
    {req_ch.command, req_ch.pipe_index, req_ch.dir_in, req_ch.dev_addr, req_ch.endpoint,
     req_ch.low_speed, req_ch.max_packet, req_ch.length, req_ch.setup_addr,
     req_ch.data_addr} <= r;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Ends a burst after the current word and idles for a random gap.
  task automatic pace();
    burst_left--;
    if (burst_left <= 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 10);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic send_paced(input req_t r);
    offer(r);
    pace();
  endtask

  initial begin
    int   sent;
    req_t r;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    {req_ch.command, req_ch.pipe_index, req_ch.dir_in, req_ch.dev_addr, req_ch.endpoint,
     req_ch.low_speed, req_ch.max_packet, req_ch.length, req_ch.setup_addr,
     req_ch.data_addr} <= '0;
    burst_left = 3;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Control transfers: no data stage, short IN, largest data stage, rejections.
    send_paced(make_req(CMD_CONTROL, 5'd0, 1'b0, 7'd0, 4'd0, 1'b0, 10'd8, 16'd0,
                        32'h0, 32'h0));
    send_paced(make_req(CMD_CONTROL, 5'd1, 1'b1, 7'd5, 4'd9, 1'b0, 10'd8, 16'd8,
                        32'h0000_1000, 32'h0000_2000));
    send_paced(make_req(CMD_CONTROL, 5'd31, 1'b1, 7'd127, 4'd15, 1'b1, 10'd1023, 16'd1023,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_paced(make_req(CMD_CONTROL, 5'd2, 1'b0, 7'd64, 4'd0, 1'b1, 10'd64, 16'd1,
                        32'hAAAA_5555, 32'h5555_AAAA));
    send_paced(make_req(CMD_CONTROL, 5'd3, 1'b0, 7'd1, 4'd0, 1'b0, 10'd64, 16'd1024,
                        32'h1234_5678, 32'h9ABC_DEF0));
    send_paced(make_req(CMD_CONTROL, 5'd3, 1'b1, 7'd1, 4'd0, 1'b0, 10'd64, 16'hFFFF,
                        32'h1234_5678, 32'h9ABC_DEF0));
    // Bulk: single chunk, the longest chain, one chunk too many, zero length,
    // zero packet size, largest sizes.
    send_paced(make_req(CMD_BULK, 5'd0, 1'b0, 7'd10, 4'd1, 1'b0, 10'd1023, 16'd1,
                        32'h0, 32'h0001_0000));
    send_paced(make_req(CMD_BULK, 5'd0, 1'b1, 7'd10, 4'd1, 1'b0, 10'd1, 16'd64,
                        32'h0, 32'h0002_0000));
    send_paced(make_req(CMD_BULK, 5'd0, 1'b1, 7'd10, 4'd1, 1'b0, 10'd1, 16'd65,
                        32'h0, 32'h0002_0000));
    send_paced(make_req(CMD_BULK, 5'd0, 1'b0, 7'd10, 4'd1, 1'b0, 10'd64, 16'd0,
                        32'h0, 32'h0003_0000));
    send_paced(make_req(CMD_BULK, 5'd0, 1'b0, 7'd10, 4'd1, 1'b0, 10'd0, 16'd100,
                        32'h0, 32'h0003_0000));
    send_paced(make_req(CMD_BULK, 5'd31, 1'b1, 7'd127, 4'd15, 1'b1, 10'd1023, 16'd65472,
                        32'hFFFF_FFFF, 32'h8000_0000));
    send_paced(make_req(CMD_BULK, 5'd31, 1'b1, 7'd127, 4'd15, 1'b1, 10'd1023, 16'hFFFF,
                        32'h0, 32'h8000_0000));
    // Buffer address wraps past the top of the bus.
    send_paced(make_req(CMD_BULK, 5'd7, 1'b0, 7'd33, 4'd15, 1'b0, 10'd32, 16'd100,
                        32'h0, 32'hFFFF_FFF0));
    // Odd chunk count leaves the stored toggle set; a pipe open clears it.
    send_paced(make_req(CMD_BULK, 5'd5, 1'b0, 7'd2, 4'd3, 1'b0, 10'd1, 16'd3,
                        32'h0, 32'h0000_4000));
    send_paced(make_req(CMD_BULK, 5'd5, 1'b0, 7'd2, 4'd3, 1'b0, 10'd2, 16'd3,
                        32'h0, 32'h0000_5000));
    send_paced(make_req(CMD_OPEN, 5'd5, 1'b0, 7'd0, 4'd0, 1'b0, 10'd0, 16'd0,
                        32'h0, 32'h0));
    send_paced(make_req(CMD_BULK, 5'd5, 1'b1, 7'd2, 4'd3, 1'b0, 10'd2, 16'd3,
                        32'h0, 32'h0000_6000));
    send_paced(make_req(CMD_OPEN, 5'd31, 1'b1, 7'd127, 4'd15, 1'b1, 10'd1023, 16'hFFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_paced(make_req(CMD_BULK, 5'd31, 1'b0, 7'd127, 4'd15, 1'b1, 10'd512, 16'd513,
                        32'h0, 32'h0000_7000));
    // The unused command code is dropped without a word.
    send_paced(make_req(CMD_UNUSED, 5'd9, 1'b1, 7'd9, 4'd9, 1'b1, 10'd9, 16'd9,
                        32'h9, 32'h9));
    send_paced(make_req(CMD_CONTROL, 5'd9, 1'b0, 7'd9, 4'd0, 1'b0, 10'd8, 16'd4,
                        32'h0000_0900, 32'h0000_0A00));
    drain();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = random_request();
      offer(r);
      if (r.command != CMD_UNUSED) sent++;
      // The receiver holds off while requests keep coming, so the block backs up.
      if (sent == 40) hold_go = 1;
      if (sent == 100) begin
        drain();
        sent++;
      end else begin
        pace();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d requests (%0d rejected) and %0d descriptor words.",
             req_count, reject_count, td_count);
    $display("Stimulus mixed control, bulk, pipe open and ignored words under receiver stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: stretches of full rate, light and heavy stalling, plus one long hold-off.
  initial begin
    int holds_done;
    int mode;
    int span;
    holds_done = 0;
    td_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_go > holds_done) begin
        holds_done++;
        td_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(8, 40);
      repeat (span) begin
        case (mode)
          0: td_ch.ready <= 1'b1;
          1: td_ch.ready <= ($urandom_range(0, 3) != 0);
          default: td_ch.ready <= ($urandom_range(0, 1) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/utdb_pkg.sv
src/utdb_if.sv
src/utdb_ctrl.sv
src/utdb_dp.sv
src/usb1_transfer_descriptor_builder.sv
dv/utdb_chain_checker.sv
dv/tb_usb1_transfer_descriptor_builder.sv
